// ----- sv/mpc_pkg.sv -----
package mpc_pkg;

  localparam int IMAGE_WIDTH_DEF  = 160;
  localparam int IMAGE_HEIGHT_DEF = 80;
  localparam int ITER_CAP_DEF     = 1023;

  localparam int QFRAC = 28;

  localparam logic signed [31:0] CENTER_REAL_RST = -32'sd268435456;
  localparam logic signed [31:0] CENTER_IMAG_RST = 32'sd0;
  localparam logic [30:0]        PIXEL_STEP_RST  = 31'd5368709;
  localparam logic [9:0]         ITER_LIMIT_RST  = 10'd500;

  localparam logic [40:0] ESCAPE_BOUND = 41'd4 << QFRAC;

  typedef enum logic [1:0] {
    REG_CENTER_REAL = 2'd0,
    REG_CENTER_IMAG = 2'd1,
    REG_PIXEL_STEP  = 2'd2,
    REG_ITER_LIMIT  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR,
    ST_CI,
    ST_CFIN,
    ST_SQR,
    ST_SQI,
    ST_XY,
    ST_UPD,
    ST_DIV,
    ST_FIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sh000000007FFFFFFF) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      res = -32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] hue_to_rgb565(input logic [7:0] h);
    logic [2:0]  region;
    logic [7:0]  base;
    logic [7:0]  rem;
    logic [15:0] prod_q;
    logic [15:0] prod_t;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    priority if (h >= 8'd215) begin
      region = 3'd5;
    end else if (h >= 8'd172) begin
      region = 3'd4;
    end else if (h >= 8'd129) begin
      region = 3'd3;
    end else if (h >= 8'd86) begin
      region = 3'd2;
    end else if (h >= 8'd43) begin
      region = 3'd1;
    end else begin
      region = 3'd0;
    end
    base   = 8'(region) * 8'd43;
    rem    = 8'((h - base) * 8'd6);
    prod_q = 16'(8'd255 - 8'((16'd255 * 16'(rem)) >> 8)) * 16'd255;
    prod_t = 16'(8'd255 - 8'((16'd255 * 16'(8'd255 - rem)) >> 8)) * 16'd255;
    q      = prod_q[15:8];
    t      = prod_t[15:8];
    unique case (region)
      3'd0: begin r = 8'd255; g = t;      b = 8'd0;   end
      3'd1: begin r = q;      g = 8'd255; b = 8'd0;   end
      3'd2: begin r = 8'd0;   g = 8'd255; b = t;      end
      3'd3: begin r = 8'd0;   g = q;      b = 8'd255; end
      3'd4: begin r = t;      g = 8'd0;   b = 8'd255; end
      default: begin r = 8'd255; g = 8'd0; b = q;     end
    endcase
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ----- sv/mandelbrot_pixel_colorizer.sv -----
// Mandelbrot escape-time pixel colorizer.
// Pulse start with in_pixel_col / in_pixel_row while busy is low to hand in one
// item. The block forms the point c from the center and pixel step registers,
// iterates z = z*z + c in signed Q4.28 and returns one result: the echoed
// coordinates, the iteration count and an RGB565 hue color (black for a pixel
// that reaches the limit). The result is shown for one cycle with out_valid
// high; the receiver must take it then, it cannot stall the block.
// Configuration goes through the APB port: center_real at 0x0, center_imag at
// 0x4, pixel_step at 0x8, iteration_limit at 0xC; write only while idle.
// c is formed in the steps ST_CR, ST_CI and ST_CFIN; each iteration then runs
// ST_SQR, ST_SQI, ST_XY and ST_UPD; ST_SQR ends the loop at the limit and
// ST_UPD tests for escape. An escaping pixel then runs the bit-serial hue
// divide in ST_DIV, and every pixel ends in ST_FIN. The single 32x32 multiplier
// is shared over zr*zr, zi*zi and zr*zi each iteration. busy stays high from
// acceptance until the result strobe; a new item may start in the strobe cycle.
// Reset returns the sequencer to idle, drops out_valid and loads the register
// defaults (center -1.0 + 0i, step 0.02, limit 500).
module mandelbrot_pixel_colorizer #(
  parameter int IMAGE_WIDTH  = mpc_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = mpc_pkg::IMAGE_HEIGHT_DEF,
  parameter int ITER_CAP     = mpc_pkg::ITER_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_pixel_col,
  input  logic [6:0]  in_pixel_row,
  output logic        out_valid,
  output logic [7:0]  out_pixel_col_out,
  output logic [6:0]  out_pixel_row_out,
  output logic [15:0] out_color_rgb565,
  output logic [9:0]  out_iteration_count
);

  localparam logic signed [11:0] HALF_W = 12'(IMAGE_WIDTH / 2);
  localparam logic signed [11:0] HALF_H = 12'(IMAGE_HEIGHT / 2);
  localparam logic [16:0]        CAP_V  = 17'(ITER_CAP);

  mpc_pkg::state_t state_r, state_nxt;

  logic signed [31:0] center_real_r;
  logic signed [31:0] center_imag_r;
  logic [30:0]        pixel_step_r;
  logic [9:0]         iter_limit_r;

  logic [7:0]         col_r, col_nxt;
  logic [6:0]         row_r, row_nxt;
  logic [9:0]         limit_r, limit_nxt;
  logic [9:0]         iter_r, iter_nxt;
  logic signed [31:0] cr_r, cr_nxt;
  logic signed [31:0] ci_r, ci_nxt;
  logic signed [31:0] zr_r, zr_nxt;
  logic signed [31:0] zi_r, zi_nxt;
  logic signed [39:0] sr_r, sr_nxt;
  logic signed [39:0] si_r, si_nxt;
  logic signed [63:0] product_r, product_nxt;
  logic [17:0]        rem_r, rem_nxt;
  logic [16:0]        dsh_r, dsh_nxt;
  logic [7:0]         quo_r, quo_nxt;
  logic [2:0]         div_cnt_r, div_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_col_r, out_col_nxt;
  logic [6:0]         out_row_r, out_row_nxt;
  logic [15:0]        out_color_r, out_color_nxt;
  logic [9:0]         out_iter_r, out_iter_nxt;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic [40:0]        mag;
  logic               escape;
  logic               accept;
  logic               cfg_wr;
  logic [9:0]         limit_in;

  assign accept = start && !busy;
  assign busy   = (state_r != mpc_pkg::ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign dx = 32'(($signed({4'b0, col_r}) - HALF_W));
  assign dy = 32'(($signed({5'b0, row_r}) - HALF_H));

  assign mag    = 41'(sr_r) + 41'(si_r);
  assign escape = (mag >= mpc_pkg::ESCAPE_BOUND);

  assign limit_in = ({7'b0, iter_limit_r} > CAP_V) ? CAP_V[9:0] : iter_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_real_r <= mpc_pkg::CENTER_REAL_RST;
      center_imag_r <= mpc_pkg::CENTER_IMAG_RST;
      pixel_step_r  <= mpc_pkg::PIXEL_STEP_RST;
      iter_limit_r  <= mpc_pkg::ITER_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (mpc_pkg::reg_idx_t'(paddr[3:2]))
        mpc_pkg::REG_CENTER_REAL: center_real_r <= $signed(pwdata);
        mpc_pkg::REG_CENTER_IMAG: center_imag_r <= $signed(pwdata);
        mpc_pkg::REG_PIXEL_STEP:  pixel_step_r  <= pwdata[30:0];
        mpc_pkg::REG_ITER_LIMIT:  iter_limit_r  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mpc_pkg::reg_idx_t'(paddr[3:2]))
      mpc_pkg::REG_CENTER_REAL: prdata = center_real_r;
      mpc_pkg::REG_CENTER_IMAG: prdata = center_imag_r;
      mpc_pkg::REG_PIXEL_STEP:  prdata = {1'b0, pixel_step_r};
      mpc_pkg::REG_ITER_LIMIT:  prdata = {22'b0, iter_limit_r};
      default:                  prdata = 32'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpc_pkg::ST_IDLE: if (start) state_nxt = mpc_pkg::ST_CR;
      mpc_pkg::ST_CR:   state_nxt = mpc_pkg::ST_CI;
      mpc_pkg::ST_CI:   state_nxt = mpc_pkg::ST_CFIN;
      mpc_pkg::ST_CFIN: state_nxt = mpc_pkg::ST_SQR;
      mpc_pkg::ST_SQR: begin
        state_nxt = (iter_r < limit_r) ? mpc_pkg::ST_SQI : mpc_pkg::ST_FIN;
      end
      mpc_pkg::ST_SQI:  state_nxt = mpc_pkg::ST_XY;
      mpc_pkg::ST_XY:   state_nxt = mpc_pkg::ST_UPD;
      mpc_pkg::ST_UPD:  state_nxt = escape ? mpc_pkg::ST_DIV : mpc_pkg::ST_SQR;
      mpc_pkg::ST_DIV:  if (div_cnt_r == 3'd7) state_nxt = mpc_pkg::ST_FIN;
      mpc_pkg::ST_FIN:  state_nxt = mpc_pkg::ST_IDLE;
      default:          state_nxt = mpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      mpc_pkg::ST_CR:  begin mul_a = dx;   mul_b = $signed({1'b0, pixel_step_r}); end
      mpc_pkg::ST_CI:  begin mul_a = dy;   mul_b = $signed({1'b0, pixel_step_r}); end
      mpc_pkg::ST_SQR: begin mul_a = zr_r; mul_b = zr_r; end
      mpc_pkg::ST_SQI: begin mul_a = zi_r; mul_b = zi_r; end
      default:         begin mul_a = zr_r; mul_b = zi_r; end
    endcase
    product_nxt = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    limit_nxt     = limit_r;
    iter_nxt      = iter_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    sr_nxt        = sr_r;
    si_nxt        = si_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = 1'b0;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_color_nxt = out_color_r;
    out_iter_nxt  = out_iter_r;
    unique case (state_r)
      mpc_pkg::ST_IDLE: begin
        if (start) begin
          col_nxt   = in_pixel_col;
          row_nxt   = in_pixel_row;
          limit_nxt = limit_in;
          iter_nxt  = 10'd0;
        end
      end
      mpc_pkg::ST_CI: begin
        cr_nxt = mpc_pkg::sat32(64'(center_real_r) + product_r);
      end
      mpc_pkg::ST_CFIN: begin
        ci_nxt = mpc_pkg::sat32(64'(center_imag_r) + product_r);
        zr_nxt = 32'sd0;
        zi_nxt = 32'sd0;
      end
      mpc_pkg::ST_SQI: begin
        sr_nxt = 40'(product_r >>> mpc_pkg::QFRAC);
      end
      mpc_pkg::ST_XY: begin
        si_nxt = 40'(product_r >>> mpc_pkg::QFRAC);
      end
      mpc_pkg::ST_UPD: begin
        if (escape) begin
          rem_nxt     = 18'({iter_r, 8'b0}) - 18'(iter_r);
          dsh_nxt     = {limit_r, 7'b0};
          quo_nxt     = 8'd0;
          div_cnt_nxt = 3'd0;
        end else begin
          zr_nxt   = mpc_pkg::sat32(64'(sr_r) - 64'(si_r) + 64'(cr_r));
          zi_nxt   = mpc_pkg::sat32((product_r >>> (mpc_pkg::QFRAC - 1)) + 64'(ci_r));
          iter_nxt = iter_r + 10'd1;
        end
      end
      mpc_pkg::ST_DIV: begin
        if (rem_r >= {1'b0, dsh_r}) begin
          rem_nxt = rem_r - {1'b0, dsh_r};
          quo_nxt = {quo_r[6:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[6:0], 1'b0};
        end
        dsh_nxt     = dsh_r >> 1;
        div_cnt_nxt = div_cnt_r + 3'd1;
      end
      mpc_pkg::ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_col_nxt   = col_r;
        out_row_nxt   = row_r;
        out_iter_nxt  = iter_r;
        out_color_nxt = (iter_r < limit_r) ? mpc_pkg::hue_to_rgb565(quo_r) : 16'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    limit_r     <= limit_nxt;
    iter_r      <= iter_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    sr_r        <= sr_nxt;
    si_r        <= si_nxt;
    product_r   <= product_nxt;
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    quo_r       <= quo_nxt;
    div_cnt_r   <= div_cnt_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_color_r <= out_color_nxt;
    out_iter_r  <= out_iter_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_col_out   = out_col_r;
  assign out_pixel_row_out   = out_row_r;
  assign out_color_rgb565    = out_color_r;
  assign out_iteration_count = out_iter_r;

  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == mpc_pkg::ST_FIN))
    else $error("result strobe without finish step");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && state_r != mpc_pkg::ST_CR) |-> (iter_r <= limit_r))
    else $error("iteration count above limit");

  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_iteration_count == limit_r) |-> (out_color_rgb565 == 16'd0))
    else $error("pixel at limit not black");

endmodule
